### rtl/rrff_pkg.sv
// ----------------------------------------------------------------------------
// rrff_pkg
// Shared types and constants of the receive ring frame fetcher: item
// layouts, operation and status codes, controller states, reset values.
// ----------------------------------------------------------------------------
package rrff_pkg;

  // Operation carried by one input item
  typedef enum logic [1:0] {
    KIND_STORE_HEADER = 2'd0,
    KIND_SET_WRITE    = 2'd1,
    KIND_FETCH        = 2'd2,
    KIND_RESTART      = 2'd3
  } kind_e;

  // Outcome reported with each result item
  typedef enum logic [1:0] {
    STATUS_READY    = 2'd0,
    STATUS_EMPTY    = 2'd1,
    STATUS_BAD_HDR  = 2'd2,
    STATUS_ACCEPTED = 2'd3
  } status_e;

  // Configuration register indexes
  typedef enum logic {
    REG_RING_START = 1'b0,
    REG_RING_STOP  = 1'b1
  } reg_idx_e;

  // Controller states
  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_LOOKUP = 1'b1
  } state_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  page;
    logic [7:0]  header_next;
    logic [15:0] header_count;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] first_address;
    logic [10:0] first_length;
    logic [15:0] second_address;
    logic [10:0] second_length;
    logic [7:0]  next_page;
    logic [7:0]  boundary_page;
  } out_item_t;

  // Header bytes in front of each frame payload
  localparam logic [15:0] HDR_BYTES = 16'd4;
  localparam int unsigned HDR_WIDTH = 24;

  // Register reset values
  localparam logic [7:0] RING_START_RST = 8'd70;
  localparam logic [7:0] RING_STOP_RST  = 8'd128;

endpackage

### rtl/rrff_stream_if.sv
// ----------------------------------------------------------------------------
// rrff_stream_if
// Valid/ready channel carrying one item per transfer.
// ----------------------------------------------------------------------------
interface rrff_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/rrff_ram.sv
// ----------------------------------------------------------------------------
// rrff_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rrff_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/receive_ring_frame_fetcher_top.sv
// ----------------------------------------------------------------------------
// receive_ring_frame_fetcher_top
// Consumer side of a paged receive ring: header store, empty check, header
// validation, payload split at the ring end, read page and boundary advance.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries commands (store page header, set write page, fetch frame,
//   restart ring); out_o carries one result per command. Both are valid/ready
//   channels; a transfer happens when valid and ready are high at a clock edge.
//   cfg_we_i/cfg_idx_i/cfg_wdata_i write ring start (index 0) and ring stop
//   (index 1); write them only while no command is in flight.
// Timing:
//   A command is taken in the idle state; the header memory is read at that
//   edge and the result register loads when the lookup state ends, which it
//   does once the output register is empty or being drained. The idle/lookup
//   controller takes no new command until the current one has left lookup.
//   in_i takes a new command while a result still waits in the output
//   register; that command then holds in the lookup stage until the result is
//   taken.
// Reset:
//   Ring start 70, ring stop 128, read and write page ring start + 1, boundary
//   ring start. Header memory contents are undefined until stored.
// ----------------------------------------------------------------------------
module receive_ring_frame_fetcher_top
  import rrff_pkg::*;
#(
  parameter int unsigned PAGE_COUNT      = 256,
  parameter int unsigned MIN_FRAME_BYTES = 60,
  parameter int unsigned MAX_FRAME_BYTES = 1518
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  rrff_stream_if.sink   in_i,
  rrff_stream_if.source out_o
);

  localparam int unsigned AW = $clog2(PAGE_COUNT);
  localparam logic [8:0]  PAGE_LIMIT = 9'(PAGE_COUNT);
  localparam logic [16:0] CNT_LO = 17'(MIN_FRAME_BYTES) + 17'(HDR_BYTES);
  localparam logic [16:0] CNT_HI = 17'(MAX_FRAME_BYTES) + 17'(HDR_BYTES);

  state_e state_q, state_d;

  logic [7:0] start_q, stop_q;
  logic [7:0] read_page_q, read_page_d;
  logic [7:0] write_page_q, write_page_d;
  logic [7:0] boundary_q, boundary_d;

  kind_e      kind_q;
  logic [7:0] page_q;
  logic       oor_q;

  out_item_t  out_q, out_d;
  logic       out_valid_q;

  logic       in_fire, out_fire, lookup_done;
  logic       mem_we;
  logic [HDR_WIDTH-1:0] mem_rdata;

  // Lookup datapath
  logic [7:0]  nx;
  logic [15:0] cnt;
  logic        is_empty, is_bad;
  logic [15:0] len, addr, stop_addr, room, first;
  logic [7:0]  restart_page;

  assign in_fire  = in_i.valid & in_i.ready;
  assign out_fire = out_o.valid & out_o.ready;

  // Header store: write on store commands, read the current read page on accept
  assign mem_we = in_fire && (in_i.data.kind == KIND_STORE_HEADER) &&
                  ({1'b0, in_i.data.page} < PAGE_LIMIT);

  rrff_ram #(
    .WIDTH (HDR_WIDTH),
    .DEPTH (PAGE_COUNT)
  ) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (in_i.data.page[AW-1:0]),
    .wdata_i ({in_i.data.header_next, in_i.data.header_count}),
    .re_i    (in_fire),
    .raddr_i (read_page_q[AW-1:0]),
    .rdata_o (mem_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) state_d = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        if (lookup_done) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Controller outputs
  always_comb begin
    in_i.ready  = 1'b0;
    lookup_done = 1'b0;
    case (state_q)
      ST_IDLE:   in_i.ready  = 1'b1;
      ST_LOOKUP: lookup_done = ~out_valid_q | out_o.ready;
      default: begin
        in_i.ready  = 1'b0;
        lookup_done = 1'b0;
      end
    endcase
  end

  // Header check and payload split
  always_comb begin
    nx           = oor_q ? 8'd0 : mem_rdata[23:16];
    cnt          = oor_q ? 16'd0 : mem_rdata[15:0];
    is_empty     = (read_page_q == write_page_q);
    is_bad       = (nx < start_q) || (nx >= stop_q) ||
                   ({1'b0, cnt} < CNT_LO) || ({1'b0, cnt} > CNT_HI);
    len          = cnt - HDR_BYTES;
    addr         = {read_page_q, 8'h00} + HDR_BYTES;
    stop_addr    = {stop_q, 8'h00};
    room         = (addr < stop_addr) ? (stop_addr - addr) : len;
    first        = (len < room) ? len : room;
    restart_page = start_q + 8'd1;

    read_page_d  = read_page_q;
    write_page_d = write_page_q;
    boundary_d   = boundary_q;
    out_d        = '0;
    out_d.status = STATUS_ACCEPTED;

    case (kind_q)
      KIND_STORE_HEADER: ;
      KIND_SET_WRITE: write_page_d = page_q;
      KIND_RESTART: begin
        read_page_d  = restart_page;
        write_page_d = restart_page;
        boundary_d   = start_q;
      end
      KIND_FETCH: begin
        if (is_empty) begin
          out_d.status = STATUS_EMPTY;
        end else if (is_bad) begin
          out_d.status = STATUS_BAD_HDR;
          read_page_d  = restart_page;
          write_page_d = restart_page;
          boundary_d   = start_q;
        end else begin
          out_d.status         = STATUS_READY;
          out_d.first_address  = addr;
          out_d.first_length   = first[10:0];
          out_d.second_address = {start_q, 8'h00};
          out_d.second_length  = 11'(len - first);
          read_page_d          = nx;
          boundary_d           = (nx == start_q) ? (stop_q - 8'd1) : (nx - 8'd1);
        end
      end
      default: ;
    endcase

    out_d.next_page     = read_page_d;
    out_d.boundary_page = boundary_d;
  end

  // Control registers and ring pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      start_q      <= RING_START_RST;
      stop_q       <= RING_STOP_RST;
      read_page_q  <= RING_START_RST + 8'd1;
      write_page_q <= RING_START_RST + 8'd1;
      boundary_q   <= RING_START_RST;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_RING_START) start_q <= cfg_wdata_i;
        else                             stop_q  <= cfg_wdata_i;
      end
      if (lookup_done) begin
        read_page_q  <= read_page_d;
        write_page_q <= write_page_d;
        boundary_q   <= boundary_d;
        out_valid_q  <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the accepted command and the result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q <= in_i.data.kind;
      page_q <= in_i.data.page;
      oor_q  <= ({1'b0, read_page_q} >= PAGE_LIMIT);
    end
    if (lookup_done) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // An accepted command always moves to the lookup stage
  a_accept_to_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == ST_LOOKUP)
    else $error("accepted command did not enter lookup");

  // A new result only follows a lookup
  a_result_after_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_LOOKUP))
    else $error("result appeared without a lookup");

  // Addresses and lengths are zero unless a frame is ready
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.status != STATUS_READY) |->
      (out_q.first_length == 11'd0) && (out_q.second_length == 11'd0) &&
      (out_q.first_address == 16'd0) && (out_q.second_address == 16'd0))
    else $error("payload fields set on a non-frame result");

  // Header writes only happen on accepted commands in idle
  a_write_in_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> state_q == ST_IDLE)
    else $error("header write outside idle");

endmodule
